### rtl/lzd_pkg.sv
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by the front end, command queue, back end and top level.
package lzd_pkg;

  localparam int POS_BITS_DEF = 10;
  localparam int CMDQ_DEPTH   = 2;
  localparam int MIN_COUNT    = 3;

  localparam logic [15:0] FLAG_FILL  = 16'hFF00;
  localparam logic [7:0]  SPACE_BYTE = 8'h20;

  // One decoded token: a literal byte, or the two raw bytes of a match
  typedef struct packed {
    logic       is_match;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
  } lzd_cmd_t;

endpackage

### rtl/lzd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data. No dependencies.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/lzd_front.sv
// Front end: takes compressed bytes, tracks flag bits and emits token requests.
// Depends on lzd_pkg.
module lzd_front
  import lzd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  logic [7:0] in_byte,
  output logic     cmd_push,
  output lzd_cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_FLAG  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_MATCH = 3'b100
  } lzd_phase_t;

  lzd_phase_t  phase_r, phase_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic [7:0]  held_r, held_nxt;

  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    held_nxt  = held_r;
    cmd_push  = 1'b0;
    cmd       = '{is_match: 1'b0, lo_byte: in_byte, hi_byte: in_byte};
    if (take) begin
      unique case (phase_r)
        PH_TOKEN: begin
          if (flag_r[0]) begin
            cmd_push  = 1'b1;
            flag_nxt  = flag_r >> 1;
            phase_nxt = flag_r[9] ? PH_TOKEN : PH_FLAG;
          end else begin
            held_nxt  = in_byte;
            phase_nxt = PH_MATCH;
          end
        end
        PH_MATCH: begin
          cmd_push     = 1'b1;
          cmd.is_match = 1'b1;
          cmd.lo_byte  = held_r;
          flag_nxt     = flag_r >> 1;
          phase_nxt    = flag_r[9] ? PH_TOKEN : PH_FLAG;
        end
        default: begin
          // flag byte: eight tokens follow, marker ones above them
          flag_nxt  = 16'(in_byte) | FLAG_FILL;
          phase_nxt = PH_TOKEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flag_r  <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      held_r  <= held_nxt;
    end
  end

  a_push_only_on_token: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (phase_r == PH_TOKEN || phase_r == PH_MATCH))
    else $error("token request raised while awaiting a flag byte");

endmodule

### rtl/lzd_cmdq.sv
// Short register queue of token requests between front end and back end.
// Depends on lzd_pkg.
module lzd_cmdq
  import lzd_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lzd_cmd_t push_cmd,
  input  logic     pop,
  output lzd_cmd_t head,
  output logic     full,
  output logic     empty
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  lzd_cmd_t        q_r [DEPTH];
  logic [IdxW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == IdxW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == IdxW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/lzd_back.sv
// Back end: history ring, clearing pass, literal writes, match copies and the
// output register pairing bytes. Depends on lzd_pkg and lzd_ram.
module lzd_back
  import lzd_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lzd_cmd_t   cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       ring_ready,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte_first,
  output logic [7:0] out_byte_second,
  output logic       out_second_valid,
  output logic       out_last
);

  localparam int PosW      = POSITION_BITS;
  localparam int LenBits   = 16 - POSITION_BITS;
  localparam int RingDepth = 1 << POSITION_BITS;
  localparam int CopySpan  = (1 << LenBits) + 2;
  localparam int FillEnd   = (RingDepth > CopySpan) ? RingDepth - CopySpan : 0;
  localparam int CntW      = LenBits + 1;
  localparam logic [PosW-1:0] FillPos = PosW'(FillEnd);
  localparam logic [7:0]      LenMask = 8'((1 << LenBits) - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_COPY  = 3'b100
  } lzd_bstate_t;

  lzd_bstate_t     st_r, st_nxt;
  logic [PosW-1:0] clr_r, clr_nxt;
  logic [PosW-1:0] wp_r, wp_nxt;
  logic [PosW-1:0] src_r, src_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic            half_r, half_nxt;
  logic [7:0]      first_r, first_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      ob_first_r, ob_first_nxt;
  logic [7:0]      ob_second_r, ob_second_nxt;
  logic            osv_r, osv_nxt;
  logic            olast_r, olast_nxt;

  logic            ram_we, ram_re;
  logic [PosW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  logic            go;
  logic            emit;
  logic [7:0]      e_first, e_second;
  logic            e_sv, e_last;
  logic [PosW-1:0] pos_c;
  logic [CntW-1:0] cnt_c;

  lzd_ram #(
    .WIDTH(8),
    .DEPTH(RingDepth)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // match source: low byte plus the bits of the second byte above the length field
  assign pos_c    = PosW'({8'(cmd.hi_byte >> LenBits), cmd.lo_byte});
  assign cnt_c    = CntW'(cmd.hi_byte & LenMask) + CntW'(MIN_COUNT);

  assign go         = !out_valid_r || out_pop;
  assign ring_ready = (st_r != ST_CLEAR);

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    wp_nxt    = wp_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    half_nxt  = half_r;
    first_nxt = first_r;
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = src_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_first   = ram_rdata;
    e_second  = '0;
    e_sv      = 1'b0;
    e_last    = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r < FillPos) ? SPACE_BYTE : 8'h00;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty && go) begin
          cmd_pop = 1'b1;
          if (cmd.is_match) begin
            ram_re    = 1'b1;
            ram_raddr = pos_c;
            src_nxt   = pos_c + 1'b1;
            rem_nxt   = cnt_c;
            half_nxt  = 1'b0;
            st_nxt    = ST_COPY;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = cmd.lo_byte;
            wp_nxt    = wp_r + 1'b1;
            emit      = 1'b1;
            e_first   = cmd.lo_byte;
            e_last    = 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (go) begin
          // write back the byte just read, fetch the next one
          ram_we  = 1'b1;
          wp_nxt  = wp_r + 1'b1;
          ram_re  = 1'b1;
          src_nxt = src_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == CntW'(1)) begin
            emit     = 1'b1;
            e_first  = half_r ? first_r : ram_rdata;
            e_second = half_r ? ram_rdata : 8'h00;
            e_sv     = half_r;
            e_last   = 1'b1;
            half_nxt = 1'b0;
            st_nxt   = ST_IDLE;
          end else if (half_r) begin
            emit     = 1'b1;
            e_first  = first_r;
            e_second = ram_rdata;
            e_sv     = 1'b1;
            half_nxt = 1'b0;
          end else begin
            first_nxt = ram_rdata;
            half_nxt  = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    ob_first_nxt  = ob_first_r;
    ob_second_nxt = ob_second_r;
    osv_nxt       = osv_r;
    olast_nxt     = olast_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      ob_first_nxt  = e_first;
      ob_second_nxt = e_second;
      osv_nxt       = e_sv;
      olast_nxt     = e_last;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      wp_r        <= FillPos;
      rem_r       <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      wp_r        <= wp_nxt;
      rem_r       <= rem_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    first_r     <= first_nxt;
    ob_first_r  <= ob_first_nxt;
    ob_second_r <= ob_second_nxt;
    osv_r       <= osv_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_byte_first   = ob_first_r;
  assign out_byte_second  = ob_second_r;
  assign out_second_valid = osv_r;
  assign out_last         = olast_r;

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result shown during ring clearing pass");

  a_copy_has_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COPY) |-> (rem_r != '0))
    else $error("copy running with no bytes left");

  a_half_only_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (st_r == ST_COPY))
    else $error("pending first byte outside a copy");

  a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && st_r != ST_CLEAR) |=> (wp_r == ($past(wp_r) + 1'b1)))
    else $error("write position did not advance after a ring write");

endmodule

### rtl/lzss_stream_decoder_top.sv
// Channel  Direction  Ports                                             Handshake
// input    in         in_byte                                           in_push / in_full
// result   out        out_byte_first, out_byte_second,                  out_empty / out_pop
//                     out_second_valid, out_last
//
// Flag bytes and first match bytes need no back-end work. A literal is written to the
// ring and shown as a one-byte result; a match copies one ring byte per cycle while no
// result is held on the output, through the single read port of the history RAM, with
// up to two bytes per result. After reset a clearing pass writes all 2^POSITION_BITS
// ring entries (1024 at the default size), one per cycle; in_full is high meanwhile.
// A result held on the output stalls the back end only; the front end keeps accepting
// until the two-entry request queue fills.
//
// Top level of the LZSS stream decoder. Depends on lzd_pkg, lzd_front, lzd_cmdq,
// lzd_back and lzd_ram.
module lzss_stream_decoder_top
  import lzd_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte_first,
  output logic [7:0] out_byte_second,
  output logic       out_second_valid,
  output logic       out_last
);

  lzd_cmd_t fe_cmd, q_head;
  logic     fe_push, q_full, q_empty, q_pop, ring_ready, take;

  assign in_full = q_full || !ring_ready;
  assign take    = in_push && !in_full;

  lzd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .cmd_push(fe_push),
    .cmd     (fe_cmd)
  );

  lzd_cmdq #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .push_cmd(fe_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lzd_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (q_head),
    .cmd_empty       (q_empty),
    .cmd_pop         (q_pop),
    .ring_ready      (ring_ready),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte_first  (out_byte_first),
    .out_byte_second (out_byte_second),
    .out_second_valid(out_second_valid),
    .out_last        (out_last)
  );

endmodule
